>>> sv/assert_macros.svh
// Assertion helpers shared by the checker files.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define SNW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define SNW_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> sv/snw_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// snw_pkg: shared types and constants of the transmit window
// Word formats of both channels, operation and status codes, entry format.
// -----------------------------------------------------------------------------
package snw_pkg;

	localparam int WIN_W = 9;
	localparam logic [WIN_W-1:0] WIN_RESET = 9'd256;
	localparam logic [31:0] SEQ_ALL_ONES = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_GET   = 2'd1,
		OP_POP   = 2'd2,
		OP_CHECK = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOT_IN = 2'd1,
		ST_EMPTY  = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] seq_number;
		logic [31:0] payload_handle;
		logic [15:0] packet_length;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        in_window;
		logic [31:0] found_handle;
		logic [15:0] found_length;
		logic [31:0] assigned_seq;
		logic        freed_valid;
		logic [31:0] freed_handle;
		logic [31:0] lead_seq;
		logic [31:0] trail_seq;
		logic [31:0] next_seq;
	} out_word_t;

	// One stored packet entry
	typedef struct packed {
		logic [31:0] handle;
		logic [15:0] length;
	} entry_t;

	// Outcome of one step, before the entry memory answers
	typedef struct packed {
		logic [1:0]  status;
		logic        in_window;
		logic        get_hit;
		logic [31:0] assigned_seq;
		logic        freed_valid;
		logic [31:0] lead_seq;
		logic [31:0] trail_seq;
		logic [31:0] next_seq;
	} step_res_t;

endpackage

>>> sv/seq_numbered_transmit_window.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// seq_numbered_transmit_window: retransmit window over 32-bit sequence numbers
// Push, get, pop and check on a ring of packet entries held in one memory.
// -----------------------------------------------------------------------------
// Every accepted word gives exactly one result word. A word is decoded and
// its entry memory access (one write, one read, or both for an evicting
// push) issued at the accept edge; the registered read data and the step
// outcome merge into the output register at the next edge unless a stalled
// result still holds it. The single read port and write port of the entry
// memory set the rate at one word per cycle, which holds as long as results
// are taken; when the output register is full and not drained, intake stops
// after one word in flight. window_size may only be written while no word is
// in flight. The memory needs no clearing pass.
module seq_numbered_transmit_window
	import snw_pkg::*;
#(
	parameter int DEPTH = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wen,
	input  logic [WIN_W-1:0] cfg_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_word_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_word_t        out_data
);

	localparam int SLOT_W = $clog2(DEPTH);

	logic [WIN_W-1:0]  window_size_q;
	logic              accept, load;
	step_res_t         res, res_s1;
	logic              busy_s1;
	logic              mem_we, mem_re;
	logic [SLOT_W-1:0] mem_waddr, mem_raddr;
	entry_t            mem_wdata, mem_rdata;
	logic              out_valid_q;
	out_word_t         out_data_q;

	// Hold the window size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WIN_RESET;
		end else if (cfg_wen) begin
			window_size_q <= cfg_wdata;
		end
	end

	assign load     = busy_s1 && (!out_valid_q || out_ready);
	assign in_ready = !busy_s1 || load;
	assign accept   = in_valid && in_ready;

	snw_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (accept),
		.cmd         (in_data),
		.window_size (window_size_q),
		.res         (res),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr)
	);

	snw_mem #(.DEPTH(DEPTH)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Track the word waiting on its memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (accept) begin
			busy_s1 <= 1'b1;
		end else if (load) begin
			busy_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Merge step outcome with read data
	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q.status       <= res_s1.status;
			out_data_q.in_window    <= res_s1.in_window;
			out_data_q.found_handle <= res_s1.get_hit ? mem_rdata.handle : 32'd0;
			out_data_q.found_length <= res_s1.get_hit ? mem_rdata.length : 16'd0;
			out_data_q.assigned_seq <= res_s1.assigned_seq;
			out_data_q.freed_valid  <= res_s1.freed_valid;
			out_data_q.freed_handle <= res_s1.freed_valid ? mem_rdata.handle : 32'd0;
			out_data_q.lead_seq     <= res_s1.lead_seq;
			out_data_q.trail_seq    <= res_s1.trail_seq;
			out_data_q.next_seq     <= res_s1.next_seq;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

>>> sv/snw_mem.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// snw_mem: entry memory
// One write port and one read port, read data registered, read-first on
// a same-entry collision.
// -----------------------------------------------------------------------------
module snw_mem
	import snw_pkg::*;
#(
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  entry_t                   wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output entry_t                   rdata
);

	entry_t mem [DEPTH];
	entry_t rdata_q;

	// Write and read in one clocked block; a read sees the old entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/snw_ctrl.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// snw_ctrl: window pointers and step decode
// Holds trail, lead, next, trail slot and entry count, decodes one word per
// step and issues the entry memory access.
// -----------------------------------------------------------------------------
module snw_ctrl
	import snw_pkg::*;
#(
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  in_word_t                 cmd,
	input  logic [WIN_W-1:0]         window_size,
	output step_res_t                res,
	output logic                     mem_we,
	output logic [$clog2(DEPTH)-1:0] mem_waddr,
	output entry_t                   mem_wdata,
	output logic                     mem_re,
	output logic [$clog2(DEPTH)-1:0] mem_raddr
);

	localparam int SLOT_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SUM_W  = CNT_W + 1;

	logic [31:0]       trail_q, lead_q, next_q;
	logic [SLOT_W-1:0] tslot_q;
	logic [CNT_W-1:0]  count_q;

	logic [31:0]       trail_n, lead_n, next_n;
	logic [SLOT_W-1:0] tslot_n, tslot_inc;
	logic [CNT_W-1:0]  count_n;

	logic [31:0]       eff_win, count_ext, seq_off;
	logic              full, empty, hit;
	logic [SLOT_W-1:0] get_slot, push_slot;

	// Fold a sum below twice the depth back into the ring
	function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SUM_W-1:0] sum);
		logic [SUM_W-1:0] r;
		r = sum;
		if (sum >= SUM_W'(DEPTH)) begin
			r = sum - SUM_W'(DEPTH);
		end
		return r[SLOT_W-1:0];
	endfunction

	// Clamp the window size to one .. DEPTH
	always_comb begin
		eff_win = {{(32 - WIN_W){1'b0}}, window_size};
		if (window_size == '0) begin
			eff_win = 32'd1;
		end else if (eff_win > 32'(DEPTH)) begin
			eff_win = 32'(DEPTH);
		end
	end

	assign count_ext = 32'(count_q);
	assign full      = (count_ext >= eff_win) && (count_q != '0);
	assign empty     = (count_q == '0);
	assign seq_off   = cmd.seq_number - trail_q;
	assign hit       = seq_off < count_ext;
	assign get_slot  = wrap_slot(SUM_W'(tslot_q) + SUM_W'(seq_off[CNT_W-1:0]));
	assign push_slot = wrap_slot(SUM_W'(tslot_q) + SUM_W'(count_q));
	assign tslot_inc = (tslot_q == SLOT_W'(DEPTH - 1)) ? '0 : tslot_q + SLOT_W'(1);

	// Decode the word, plan the memory access and the pointer update
	always_comb begin
		trail_n   = trail_q;
		lead_n    = lead_q;
		next_n    = next_q;
		tslot_n   = tslot_q;
		count_n   = count_q;
		mem_we    = 1'b0;
		mem_waddr = push_slot;
		mem_wdata = '{handle: cmd.payload_handle, length: cmd.packet_length};
		mem_re    = 1'b0;
		mem_raddr = tslot_q;
		res       = '0;
		res.status = ST_OK;
		case (cmd.opcode)
			OP_PUSH: begin
				if (full) begin
					mem_re          = step;
					res.freed_valid = 1'b1;
					trail_n         = trail_q + 32'd1;
					tslot_n         = tslot_inc;
				end else begin
					count_n = count_q + CNT_W'(1);
				end
				mem_we           = step;
				res.assigned_seq = next_q;
				lead_n           = next_q;
				next_n           = next_q + 32'd1;
			end
			OP_POP: begin
				if (empty) begin
					res.status = ST_EMPTY;
				end else begin
					mem_re          = step;
					res.freed_valid = 1'b1;
					trail_n         = trail_q + 32'd1;
					tslot_n         = tslot_inc;
					count_n         = count_q - CNT_W'(1);
				end
			end
			default: begin
				if (empty) begin
					res.status = ST_EMPTY;
				end else if (!hit) begin
					res.status = ST_NOT_IN;
				end else begin
					res.in_window = 1'b1;
					if (cmd.opcode == OP_GET) begin
						res.get_hit = 1'b1;
						mem_re      = step;
						mem_raddr   = get_slot;
					end
				end
			end
		endcase
		res.lead_seq  = lead_n;
		res.trail_seq = trail_n;
		res.next_seq  = next_n;
	end

	// Advance the pointers on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trail_q <= '0;
			lead_q  <= SEQ_ALL_ONES;
			next_q  <= '0;
			tslot_q <= '0;
			count_q <= '0;
		end else if (step) begin
			trail_q <= trail_n;
			lead_q  <= lead_n;
			next_q  <= next_n;
			tslot_q <= tslot_n;
			count_q <= count_n;
		end
	end

endmodule

>>> sv/snw_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// snw_checker: port-level checks of the transmit window
// Watches the result channel and its fields; bound to the top level.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module snw_checker
	import snw_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_data
);

	logic stall, next_ok, freed_or_hit, status_ok, hit_and_free;

	assign stall        = out_valid && !out_ready;
	assign next_ok      = (out_data.next_seq == out_data.lead_seq + 32'd1);
	assign freed_or_hit = out_data.freed_valid || out_data.in_window;
	assign status_ok    = (out_data.status == ST_OK);
	assign hit_and_free = out_data.in_window && out_data.freed_valid;

	// Hold a stalled result word
	`SNW_ASSERT(a_out_hold, stall |=> out_valid && $stable(out_data), "stalled word changed")

	// Next sequence always follows the lead
	`SNW_ASSERT(a_next_after_lead, out_valid |-> next_ok, "next_seq is not lead_seq plus one")

	// Release or membership only with an ok status
	`SNW_ASSERT(a_ok_status, out_valid && freed_or_hit |-> status_ok, "release or hit not ok")

	// A membership hit never frees a handle
	`SNW_NEVER(a_hit_no_free, out_valid && hit_and_free, "hit and release in one word")

endmodule

bind seq_numbered_transmit_window snw_checker u_snw_checker (.*);

>>> tb/sv/seq_numbered_transmit_window_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// seq_numbered_transmit_window_tb: self-checking bench for the transmit window
// Drives push, get, pop and check words with random idle and stall bursts,
// predicts every result word from a shadow copy of the ring and its pointers,
// and compares each result field by field. Window size is rewritten between
// phases, from zero and one up to the saturating top of the field.
// -----------------------------------------------------------------------------
module seq_numbered_transmit_window_tb;
	import snw_pkg::*;

	localparam int RING = 256;
	localparam int QUIET_LIMIT = 2000;
	localparam int N_PHASES = 10;

	// Shadow of the window: predicts one result word per accepted word
	class window_scoreboard;
		logic [31:0] ring_handle [RING];
		logic [15:0] ring_length [RING];
		logic [31:0] lead;
		logic [31:0] trail;
		logic [31:0] next_sq;
		logic [7:0]  trail_slot;
		logic [8:0]  count;
		logic [8:0]  win;
		out_word_t   expected_q [$];
		int errors;
		int n_words;
		int n_evict;
		int n_hit;
		int n_miss;
		int n_empty;

		function new();
			foreach (ring_handle[i]) begin
				ring_handle[i] = '0;
				ring_length[i] = '0;
			end
			lead = SEQ_ALL_ONES;
			trail = '0;
			next_sq = '0;
			trail_slot = '0;
			count = '0;
			win = WIN_RESET;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Release the oldest entry and return its handle
		function logic [31:0] retire_trail();
			logic [31:0] h;
			h = ring_handle[trail_slot];
			trail++;
			trail_slot++;
			count--;
			return h;
		endfunction

		function void note_input(in_word_t w);
			out_word_t r;
			int eff;
			logic [7:0] slot;
			logic [31:0] seq_off;
			r = '0;
			n_words++;
			// zero acts as one, anything above the ring depth saturates
			eff = (win == 0) ? 1 : ((win > RING) ? RING : int'(win));
			seq_off = w.seq_number - trail;
			case (op_t'(w.opcode))
				OP_PUSH: begin
					// evict first when the window is full or was shrunk below count
					if (count >= eff && count != 0) begin
						r.freed_valid = 1'b1;
						r.freed_handle = retire_trail();
						n_evict++;
					end
					slot = trail_slot + count[7:0];
					ring_handle[slot] = w.payload_handle;
					ring_length[slot] = w.packet_length;
					r.assigned_seq = next_sq;
					lead = next_sq;
					next_sq++;
					count++;
				end
				OP_POP: begin
					if (count == 0) begin
						r.status = ST_EMPTY;
						n_empty++;
					end else begin
						r.freed_valid = 1'b1;
						r.freed_handle = retire_trail();
					end
				end
				default: begin
					if (count == 0) begin
						r.status = ST_EMPTY;
						n_empty++;
					end else if (seq_off >= count) begin
						r.status = ST_NOT_IN;
						n_miss++;
					end else begin
						r.in_window = 1'b1;
						if (w.opcode == OP_GET) begin
							slot = trail_slot + seq_off[7:0];
							r.found_handle = ring_handle[slot];
							r.found_length = ring_length[slot];
							n_hit++;
						end
					end
				end
			endcase
			r.lead_seq = lead;
			r.trail_seq = trail;
			r.next_seq = next_sq;
			expected_q.push_back(r);
		endfunction

		function void diff(string field, logic [31:0] e, logic [31:0] a);
			if (a !== e) begin
				$error("%s mismatch: expected %0h, got %0h", field, e, a);
				errors++;
			end
		endfunction

		function void check_result(out_word_t a);
			out_word_t e;
			if (expected_q.size() == 0) begin
				$error("result word with no expectation waiting");
				errors++;
				return;
			end
			e = expected_q.pop_front();
			diff("status", 32'(e.status), 32'(a.status));
			diff("in_window", 32'(e.in_window), 32'(a.in_window));
			diff("found_handle", e.found_handle, a.found_handle);
			diff("found_length", 32'(e.found_length), 32'(a.found_length));
			diff("assigned_seq", e.assigned_seq, a.assigned_seq);
			diff("freed_valid", 32'(e.freed_valid), 32'(a.freed_valid));
			diff("freed_handle", e.freed_handle, a.freed_handle);
			diff("lead_seq", e.lead_seq, a.lead_seq);
			diff("trail_seq", e.trail_seq, a.trail_seq);
			diff("next_seq", e.next_seq, a.next_seq);
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_wen = 1'b0;
	logic [WIN_W-1:0] cfg_wdata = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	in_word_t         in_data = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_word_t        out_data;

	window_scoreboard sb = new();
	bit idle_on = 1'b1;
	int stall_left = 0;
	int quiet_cycles = 0;
	int n_settings = 0;

	// window size, length and operation mix of each random phase
	int phase_win [N_PHASES] = '{511, 1, 3, 256, 16, 0, 300, 64, 2, 256};
	int phase_len [N_PHASES] = '{150, 100, 100, 420, 150, 100, 150, 150, 100, 180};
	int phase_push [N_PHASES] = '{60, 40, 40, 75, 40, 30, 45, 50, 35, 50};
	int phase_pop [N_PHASES] = '{10, 20, 25, 5, 20, 50, 35, 30, 45, 25};

	seq_numbered_transmit_window dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Check taken result words, then decide the next stall burst
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_data);
		if (stall_left > 0)
			stall_left--;
		else if (idle_on && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 6);
		out_ready <= (stall_left == 0);
	end

	// Watchdog: end the run when no word moves on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT - 1) begin
			$display("** seq_numbered_transmit_window: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one word, with an optional idle burst first; hold until taken
	task automatic send_word(input in_word_t w);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_input(w);
	endtask

	task automatic send_op(input op_t op, input logic [31:0] seq,
			input logic [31:0] handle, input logic [15:0] len);
		in_word_t w;
		w.opcode = op;
		w.seq_number = seq;
		w.payload_handle = handle;
		w.packet_length = len;
		send_word(w);
	endtask

	// Stop sending and hold until every predicted result has arrived
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_window(input logic [WIN_W-1:0] v);
		wait_drained();
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		sb.win = v;
		n_settings++;
	endtask

	initial begin
		in_word_t w;
		int r;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty window, extreme fields, edges of the window at reset size
		send_op(OP_POP, 32'h0, 32'h0, 16'h0);
		send_op(OP_GET, 32'h0, 32'h0, 16'h0);
		send_op(OP_CHECK, SEQ_ALL_ONES, 32'h0, 16'h0);
		send_op(OP_PUSH, SEQ_ALL_ONES, 32'hFFFF_FFFF, 16'hFFFF);
		send_op(OP_PUSH, 32'h0, 32'h0, 16'h0);
		send_op(OP_PUSH, 32'h1234_5678, 32'hA5A5_5A5A, 16'h8000);
		send_op(OP_GET, 32'd0, 32'h0, 16'h0);
		send_op(OP_GET, 32'd2, 32'h0, 16'h0);
		send_op(OP_CHECK, 32'd3, 32'h0, 16'h0);
		send_op(OP_CHECK, SEQ_ALL_ONES, 32'h0, 16'h0);
		send_op(OP_GET, 32'h8000_0000, 32'h0, 16'h0);
		send_op(OP_POP, 32'h0, 32'h0, 16'h0);
		send_op(OP_CHECK, 32'd0, 32'h0, 16'h0);

		// Full window of two: each push evicts
		write_window(9'd2);
		send_op(OP_PUSH, 32'h0, 32'hDEAD_0001, 16'h0040);
		send_op(OP_PUSH, 32'h0, 32'hDEAD_0002, 16'h0041);

		// Zero acts as one, and the window is now below its count
		write_window(9'd0);
		send_op(OP_PUSH, 32'h0, 32'hDEAD_0003, 16'h0042);
		send_op(OP_GET, sb.trail, 32'h0, 16'h0);
		send_op(OP_GET, sb.lead, 32'h0, 16'h0);
		send_op(OP_POP, 32'h0, 32'h0, 16'h0);
		send_op(OP_POP, 32'h0, 32'h0, 16'h0);
		send_op(OP_POP, 32'h0, 32'h0, 16'h0);

		// Random phases, one window size each; the last runs without idle or stall bursts
		for (int p = 0; p < N_PHASES; p++) begin
			if (p == N_PHASES - 1)
				idle_on = 1'b0;
			write_window(WIN_W'(phase_win[p]));
			for (int i = 0; i < phase_len[p]; i++) begin
				if (i == phase_len[p] / 2)
					wait_drained();
				w.seq_number = $urandom;
				w.payload_handle = $urandom;
				w.packet_length = 16'($urandom_range(0, 65535));
				r = $urandom_range(0, 99);
				if (r < phase_push[p]) begin
					w.opcode = OP_PUSH;
				end else if (r < phase_push[p] + phase_pop[p]) begin
					w.opcode = OP_POP;
				end else begin
					w.opcode = $urandom_range(0, 1) ? OP_GET : OP_CHECK;
					// mostly aim inside the window, sometimes just past either end
					r = $urandom_range(0, 9);
					if (sb.count != 0 && r < 7)
						w.seq_number = sb.trail + $urandom_range(0, sb.count - 1);
					else if (r == 7)
						w.seq_number = sb.trail - 32'd1;
					else if (r == 8)
						w.seq_number = sb.trail + sb.count;
				end
				send_word(w);
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);

		$display("Covered %0d words over %0d window settings: %0d evictions, %0d get hits,",
			sb.n_words, n_settings, sb.n_evict, sb.n_hit);
		$display("%0d out-of-window replies and %0d empty-window replies.",
			sb.n_miss, sb.n_empty);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("** seq_numbered_transmit_window: PASSED **");
		else
			$display("** seq_numbered_transmit_window: FAILED **");
		$finish;
	end

endmodule
